@@ sv/tvsb_pkg.sv @@
// ----------------------------------------------------------------------------
// tvsb_pkg
// Shared types and constants for the tagged value store with bump pool.
// ----------------------------------------------------------------------------
package tvsb_pkg;

    localparam int TAG_W     = 32;
    localparam int INST_W    = 8;
    localparam int LEN_W     = 11;
    localparam int OFF_OUT_W = 10;
    localparam int STAT_W    = 2;
    localparam int OP_W      = 2;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 24;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_DEL   = 2'd2,
        OP_CLEAR = 2'd3
    } tvsb_op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_INVAL    = 2'd1,
        STAT_OOM      = 2'd2,
        STAT_NOTFOUND = 2'd3
    } tvsb_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } tvsb_state_t;

    typedef struct packed {
        logic match_hit;
        logic free_hit;
    } tvsb_scan_flags_t;

    // Replace tag bits 15:8 with a nonzero instance number.
    function automatic logic [TAG_W-1:0] eff_tag(input logic [TAG_W-1:0]  tag,
                                                 input logic [INST_W-1:0] inst);
        logic [TAG_W-1:0] res;
        res = tag;
        if (inst != '0) begin
            res[15:8] = inst;
        end
        return res;
    endfunction

endpackage

@@ sv/tvsb_ram.sv @@
// ----------------------------------------------------------------------------
// tvsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tvsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tvsb_scan.sv @@
// ----------------------------------------------------------------------------
// tvsb_scan
// Tag compare unit: walks the descriptors one per cycle and keeps the first
// matching slot and the first free slot.
// ----------------------------------------------------------------------------
module tvsb_scan #(
    parameter int ENTRIES = 32,
    parameter int OFF_W   = 11,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       cmp_vld,
    input  logic [IW-1:0]              cmp_idx,
    input  logic [tvsb_pkg::TAG_W-1:0] key_tag,
    input  logic [tvsb_pkg::TAG_W-1:0] rd_tag,
    input  logic [OFF_W-1:0]           rd_off,
    input  logic [tvsb_pkg::LEN_W-1:0] rd_len,
    input  logic                       slot_valid,
    output tvsb_pkg::tvsb_scan_flags_t flags,
    output logic [IW-1:0]              match_idx,
    output logic [IW-1:0]              free_idx,
    output logic [OFF_W-1:0]           match_off,
    output logic [tvsb_pkg::LEN_W-1:0] match_len
);
    import tvsb_pkg::*;

    tvsb_scan_flags_t  flags_reg, flags_next;
    logic [IW-1:0]     match_idx_reg, match_idx_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [OFF_W-1:0]  match_off_reg, match_off_next;
    logic [LEN_W-1:0]  match_len_reg, match_len_next;

    always_comb begin
        flags_next     = flags_reg;
        match_idx_next = match_idx_reg;
        free_idx_next  = free_idx_reg;
        match_off_next = match_off_reg;
        match_len_next = match_len_reg;
        if (start) begin
            flags_next = '0;
        end else if (cmp_vld) begin
            if (slot_valid && (rd_tag == key_tag) && !flags_reg.match_hit) begin
                flags_next.match_hit = 1'b1;
                match_idx_next       = cmp_idx;
                match_off_next       = rd_off;
                match_len_next       = rd_len;
            end
            if (!slot_valid && !flags_reg.free_hit) begin
                flags_next.free_hit = 1'b1;
                free_idx_next       = cmp_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        match_off_reg <= match_off_next;
        match_len_reg <= match_len_next;
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign free_idx  = free_idx_reg;
    assign match_off = match_off_reg;
    assign match_len = match_len_reg;

endmodule

@@ sv/tagged_value_store_bump_pool.sv @@
// ----------------------------------------------------------------------------
// tagged_value_store_bump_pool
// Tag descriptor table with a bump allocator over a byte pool.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (op, tag, instance, length) and each one
// gives exactly one result on the m_ channel (status, pool offset, length).
// Set, get and delete walk all ENTRIES descriptors through the table RAM,
// one read per cycle, with one shared tag comparator; a set with a bad length
// walks too. After the walk, a decide step writes the result register as
// soon as that register is free; clear skips the walk and goes straight to
// the decide step. The single RAM read port and the single comparator pace
// the walk. s_tready is high only between requests.
// The result sits in an output register; the next request is taken while it
// waits, and its result is held back until m_tready frees the register.
// Reset empties the table (valid bits cleared at once) and the pool; the
// block accepts a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module tagged_value_store_bump_pool #(
    parameter int ENTRIES    = 32,
    parameter int POOL_BYTES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op, tag_value, instance_req, length
    input  logic [tvsb_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, pool_offset, result_length
    output logic [tvsb_pkg::M_DATA_W-1:0] m_tdata
);
    import tvsb_pkg::*;

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int OW    = $clog2(POOL_BYTES + 1);
    localparam int SW    = ((OW > LEN_W) ? OW : LEN_W) + 1;
    localparam int RAM_W = TAG_W + OW + LEN_W;

    tvsb_state_t        state_reg, state_next;
    tvsb_op_t           op_reg, op_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CW-1:0]      issue_cnt_reg, issue_cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [OW-1:0]      pool_fill_reg, pool_fill_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               m_tvalid_reg, m_tvalid_next;
    tvsb_status_t       m_status_reg, m_status_next;
    logic [OW-1:0]      m_off_reg, m_off_next;
    logic [LEN_W-1:0]   m_len_reg, m_len_next;

    logic               s_xfer;
    logic               scan_start;
    logic               rd_en;
    tvsb_op_t           in_op;
    logic [LEN_W-1:0]   in_len;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;

    tvsb_scan_flags_t   flags;
    logic [IW-1:0]      match_idx;
    logic [IW-1:0]      free_idx;
    logic [OW-1:0]      match_off;
    logic [LEN_W-1:0]   match_len;

    logic [SW-1:0]      bump_sum;
    logic               bump_fits;
    logic               len_bad;
    logic               out_free;

    assign in_op  = tvsb_op_t'(s_tdata[1:0]);
    assign in_len = s_tdata[52:42];
    assign s_xfer = s_tvalid && s_tready;

    assign s_tready   = (state_reg == S_IDLE);
    assign scan_start = s_xfer;
    assign rd_en      = (state_reg == S_SCAN) && (issue_cnt_reg < CW'(ENTRIES));
    assign out_free   = !m_tvalid_reg || m_tready;

    assign bump_sum  = SW'(pool_fill_reg) + SW'(len_reg);
    assign bump_fits = (bump_sum <= SW'(POOL_BYTES));
    assign len_bad   = (len_reg == '0) || (SW'(len_reg) > SW'(POOL_BYTES));

    tvsb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    tvsb_scan #(
        .ENTRIES (ENTRIES),
        .OFF_W   (OW),
        .IW      (IW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .cmp_vld    (cmp_vld_reg),
        .cmp_idx    (cmp_idx_reg),
        .key_tag    (tag_reg),
        .rd_tag     (ram_rdata[RAM_W-1 -: TAG_W]),
        .rd_off     (ram_rdata[LEN_W +: OW]),
        .rd_len     (ram_rdata[LEN_W-1:0]),
        .slot_valid (valid_reg[cmp_idx_reg]),
        .flags      (flags),
        .match_idx  (match_idx),
        .free_idx   (free_idx),
        .match_off  (match_off),
        .match_len  (match_len)
    );

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        issue_cnt_next = issue_cnt_reg;
        cmp_vld_next   = rd_en;
        cmp_idx_next   = issue_cnt_reg[IW-1:0];
        pool_fill_next = pool_fill_reg;
        valid_next     = valid_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_off_next     = m_off_reg;
        m_len_next     = m_len_reg;
        ram_we         = 1'b0;
        ram_waddr      = match_idx;
        ram_wdata      = {tag_reg, match_off, len_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    op_next        = in_op;
                    tag_next       = eff_tag(s_tdata[33:2], s_tdata[41:34]);
                    len_next       = in_len;
                    issue_cnt_next = '0;
                    if (in_op == OP_CLEAR) begin
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                if (cmp_vld_reg && (cmp_idx_reg == IW'(ENTRIES - 1))) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_status_next = STAT_OK;
                    m_off_next    = '0;
                    m_len_next    = '0;
                    unique case (op_reg)
                        OP_SET: begin
                            if (len_bad) begin
                                m_status_next = STAT_INVAL;
                            end else if (flags.match_hit) begin
                                if (match_len >= len_reg) begin
                                    ram_we     = 1'b1;
                                    m_off_next = match_off;
                                    m_len_next = len_reg;
                                end else if (bump_fits) begin
                                    ram_we         = 1'b1;
                                    ram_wdata      = {tag_reg, pool_fill_reg, len_reg};
                                    pool_fill_next = bump_sum[OW-1:0];
                                    m_off_next     = pool_fill_reg;
                                    m_len_next     = len_reg;
                                end else begin
                                    m_status_next = STAT_OOM;
                                end
                            end else if (!bump_fits) begin
                                m_status_next = STAT_OOM;
                            end else begin
                                pool_fill_next = bump_sum[OW-1:0];
                                if (flags.free_hit) begin
                                    ram_we                = 1'b1;
                                    ram_waddr             = free_idx;
                                    ram_wdata             = {tag_reg, pool_fill_reg, len_reg};
                                    valid_next[free_idx]  = 1'b1;
                                    m_off_next            = pool_fill_reg;
                                    m_len_next            = len_reg;
                                end else begin
                                    m_status_next = STAT_OOM;
                                end
                            end
                        end
                        OP_GET: begin
                            if (flags.match_hit) begin
                                m_off_next = match_off;
                                m_len_next = (len_reg < match_len) ? len_reg : match_len;
                            end else begin
                                m_status_next = STAT_NOTFOUND;
                            end
                        end
                        OP_DEL: begin
                            if (flags.match_hit) begin
                                valid_next[match_idx] = 1'b0;
                            end else begin
                                m_status_next = STAT_NOTFOUND;
                            end
                        end
                        OP_CLEAR: begin
                            valid_next     = '0;
                            pool_fill_next = '0;
                        end
                        default: begin
                            m_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            pool_fill_reg <= '0;
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            pool_fill_reg <= pool_fill_next;
            valid_reg     <= valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        op_reg       <= op_next;
        tag_reg      <= tag_next;
        len_reg      <= len_next;
        cmp_idx_reg  <= cmp_idx_next;
        m_status_reg <= m_status_next;
        m_off_reg    <= m_off_next;
        m_len_reg    <= m_len_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_len_reg, OFF_OUT_W'(m_off_reg), m_status_reg};

    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result appeared without a decision step");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'(pool_fill_reg) <= SW'(POOL_BYTES))
        else $error("pool fill beyond pool size");

    a_compare_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> $past(state_reg == S_SCAN))
        else $error("tag compare outside of a table walk");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |=> !$past(s_xfer))
        else $error("request taken during a table walk");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tagged value store with bump pool.
// ----------------------------------------------------------------------------
// Sends set, get, delete and clear requests over the s_ stream and checks
// every m_ transfer against a behavioral model of the descriptor table and
// the pool fill pointer. A short table of directed requests comes first,
// then four random phases with different idle and stall rates. Each random
// phase opens with a clear and a burst of sets that runs the table full.
// ----------------------------------------------------------------------------
module testbench;
    import tvsb_pkg::*;

    localparam int N_ENTRIES  = 32;
    localparam int POOL_BYTES = 1024;
    localparam int LIMIT      = 500000;
    localparam int DIR_N      = 25;
    localparam int FILL_N     = 35;
    localparam int RAND_N     = 170;
    localparam int TAG_POOL_N = 40;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        tvsb_op_t          op;
        logic [TAG_W-1:0]  tag;
        logic [INST_W-1:0] inst;
        logic [LEN_W-1:0]  len;
    } store_req_t;

    typedef struct packed {
        tvsb_status_t          st;
        logic [OFF_OUT_W-1:0]  off;
        logic [LEN_W-1:0]      rlen;
    } store_rsp_t;

    typedef struct packed {
        store_req_t req;
        logic       typed;
        store_rsp_t rsp;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // model of the descriptor table
    logic [TAG_W-1:0]     ent_tag [N_ENTRIES];
    logic [OFF_OUT_W-1:0] ent_off [N_ENTRIES];
    logic [LEN_W-1:0]     ent_len [N_ENTRIES];
    bit                   ent_vld [N_ENTRIES];
    logic [LEN_W-1:0]     fill_bytes;

    store_rsp_t       pending_rsp [$];
    dir_row_t         dir_rows [DIR_N];
    logic [TAG_W-1:0] tag_pool [TAG_POOL_N];

    int  src_idle_pct;
    int  snk_stall_pct;
    bit  hold_req;
    int  hold_left;
    int  fail_count;
    int  cycle_cnt;
    int  op_cnt [4];
    int  st_cnt [4];

    tagged_value_store_bump_pool #(
        .ENTRIES    (N_ENTRIES),
        .POOL_BYTES (POOL_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_rsp.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic clear_table();
        for (int i = 0; i < N_ENTRIES; i++) begin
            ent_tag[i] = '0;
            ent_off[i] = '0;
            ent_len[i] = '0;
            ent_vld[i] = 1'b0;
        end
        fill_bytes = '0;
    endtask

    function automatic int find_tag(input logic [TAG_W-1:0] etag);
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (ent_vld[i] && ent_tag[i] == etag) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic apply_request(input store_req_t r, output store_rsp_t rsp);
        logic [TAG_W-1:0] etag;
        int               hit;
        int               slot;
        bit               fits;
        rsp  = '{st: STAT_OK, off: '0, rlen: '0};
        etag = r.tag;
        if (r.inst != '0) begin
            etag[15:8] = r.inst;
        end
        hit  = find_tag(etag);
        fits = (int'(fill_bytes) + int'(r.len) <= POOL_BYTES);
        case (r.op)
            OP_SET: begin
                if (r.len == '0 || r.len > POOL_BYTES) begin
                    rsp.st = STAT_INVAL;
                end else if (hit >= 0) begin
                    if (ent_len[hit] < r.len) begin
                        if (fits) begin
                            ent_off[hit] = fill_bytes[OFF_OUT_W-1:0];
                            fill_bytes   = fill_bytes + r.len;
                        end else begin
                            rsp.st = STAT_OOM;
                        end
                    end
                    if (rsp.st == STAT_OK) begin
                        ent_len[hit] = r.len;
                        rsp.off      = ent_off[hit];
                        rsp.rlen     = r.len;
                    end
                end else if (!fits) begin
                    rsp.st = STAT_OOM;
                end else begin
                    // pool space is taken even when no slot is free
                    slot      = -1;
                    for (int i = N_ENTRIES - 1; i >= 0; i--) begin
                        if (!ent_vld[i]) begin
                            slot = i;
                        end
                    end
                    rsp.off    = fill_bytes[OFF_OUT_W-1:0];
                    fill_bytes = fill_bytes + r.len;
                    if (slot < 0) begin
                        rsp.st  = STAT_OOM;
                        rsp.off = '0;
                    end else begin
                        ent_tag[slot] = etag;
                        ent_off[slot] = rsp.off;
                        ent_len[slot] = r.len;
                        ent_vld[slot] = 1'b1;
                        rsp.rlen      = r.len;
                    end
                end
            end
            OP_GET: begin
                if (hit < 0) begin
                    rsp.st = STAT_NOTFOUND;
                end else begin
                    rsp.off  = ent_off[hit];
                    rsp.rlen = (r.len < ent_len[hit]) ? r.len : ent_len[hit];
                end
            end
            OP_DEL: begin
                if (hit < 0) begin
                    rsp.st = STAT_NOTFOUND;
                end else begin
                    ent_tag[hit] = '0;
                    ent_off[hit] = '0;
                    ent_len[hit] = '0;
                    ent_vld[hit] = 1'b0;
                end
            end
            default: begin
                clear_table();
            end
        endcase
    endtask

    // Returns just after the accepting edge; the caller's next call drives on
    // the following falling edge, so tvalid holds high across back-to-back items.
    task automatic send_req(input store_req_t r, input bit typed, input store_rsp_t typed_rsp);
        store_rsp_t pred;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, r.len, r.inst, r.tag, r.op};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        apply_request(r, pred);
        pending_rsp.push_back(typed ? typed_rsp : pred);
        op_cnt[r.op]++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_rsp.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic pick_random(output store_req_t r);
        int sel;
        sel = $urandom_range(99);
        if (sel < 42) begin
            r.op = OP_SET;
        end else if (sel < 74) begin
            r.op = OP_GET;
        end else if (sel < 97) begin
            r.op = OP_DEL;
        end else begin
            r.op = OP_CLEAR;
        end
        sel    = $urandom_range(99);
        r.tag  = tag_pool[$urandom_range(TAG_POOL_N - 1)];
        r.inst = '0;
        if (sel >= 90) begin
            r.tag  = $urandom;
            r.inst = INST_W'($urandom_range(255));
        end else if (sel >= 78) begin
            r.inst = $urandom_range(1) ? INST_W'($urandom_range(1, 3))
                                       : INST_W'($urandom_range(255));
        end
        sel = $urandom_range(99);
        if (r.op == OP_GET) begin
            r.len = (sel < 50) ? LEN_W'($urandom_range(2047)) : LEN_W'($urandom_range(32));
        end else if (sel < 70) begin
            r.len = LEN_W'($urandom_range(1, 24));
        end else if (sel < 85) begin
            r.len = LEN_W'($urandom_range(25, POOL_BYTES));
        end else if (sel < 90) begin
            r.len = LEN_W'(POOL_BYTES);
        end else if (sel < 94) begin
            r.len = '0;
        end else begin
            r.len = LEN_W'($urandom_range(POOL_BYTES + 1, 2047));
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        store_rsp_t got;
        store_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.st   = tvsb_status_t'(m_tdata[1:0]);
            got.off  = m_tdata[11:2];
            got.rlen = m_tdata[22:12];
            st_cnt[got.st]++;
            if (pending_rsp.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: result with nothing pending: status %s off %0d len %0d",
                             $realtime, got.st.name(), got.off, got.rlen);
                end
            end else begin
                want = pending_rsp.pop_front();
                if (got != want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch: expected status %s off %0d len %0d,",
                                 $realtime, want.st.name(), want.off, want.rlen);
                        $display("    got status %s off %0d len %0d",
                                 got.st.name(), got.off, got.rlen);
                    end
                end
            end
        end
    end

    // receiver: random stall, plus a long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    initial begin
        store_req_t r;
        store_rsp_t none;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_req      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        fail_count    = 0;
        cycle_cnt     = 0;
        none          = '{st: STAT_OK, off: '0, rlen: '0};
        for (int i = 0; i < 4; i++) begin
            op_cnt[i] = 0;
            st_cnt[i] = 0;
        end
        for (int i = 0; i < TAG_POOL_N; i++) begin
            tag_pool[i] = $urandom;
        end
        clear_table();

        dir_rows = '{
            '{'{OP_GET,   32'h0000_0000, 8'h00, 11'd2047}, 1'b1, '{STAT_NOTFOUND, 10'd0, 11'd0}},
            '{'{OP_DEL,   32'hFFFF_FFFF, 8'h00, 11'd0},    1'b1, '{STAT_NOTFOUND, 10'd0, 11'd0}},
            '{'{OP_SET,   32'h0000_0001, 8'h00, 11'd0},    1'b1, '{STAT_INVAL,    10'd0, 11'd0}},
            '{'{OP_SET,   32'h0000_0001, 8'h00, 11'd1025}, 1'b1, '{STAT_INVAL,    10'd0, 11'd0}},
            '{'{OP_SET,   32'h0000_0001, 8'hFF, 11'd2047}, 1'b1, '{STAT_INVAL,    10'd0, 11'd0}},
            '{'{OP_SET,   32'h1122_3344, 8'h00, 11'd1024}, 1'b1, '{STAT_OK,       10'd0, 11'd1024}},
            '{'{OP_SET,   32'hAABB_CCDD, 8'h00, 11'd1},    1'b1, '{STAT_OOM,      10'd0, 11'd0}},
            '{'{OP_GET,   32'h1122_3344, 8'h00, 11'd2047}, 1'b1, '{STAT_OK,       10'd0, 11'd1024}},
            '{'{OP_GET,   32'h1122_3344, 8'h00, 11'd0},    1'b1, '{STAT_OK,       10'd0, 11'd0}},
            '{'{OP_SET,   32'h1122_3344, 8'h00, 11'd512},  1'b1, '{STAT_OK,       10'd0, 11'd512}},
            '{'{OP_SET,   32'h1122_3344, 8'h00, 11'd600},  1'b1, '{STAT_OOM,      10'd0, 11'd0}},
            '{'{OP_DEL,   32'h1122_3344, 8'h00, 11'd0},    1'b1, '{STAT_OK,       10'd0, 11'd0}},
            '{'{OP_SET,   32'h1122_3344, 8'h00, 11'd1},    1'b1, '{STAT_OOM,      10'd0, 11'd0}},
            '{'{OP_CLEAR, 32'hFFFF_FFFF, 8'hFF, 11'd2047}, 1'b1, '{STAT_OK,       10'd0, 11'd0}},
            '{'{OP_GET,   32'h1122_3344, 8'h00, 11'd4},    1'b1, '{STAT_NOTFOUND, 10'd0, 11'd0}},
            '{'{OP_SET,   32'h0000_0000, 8'h00, 11'd8},    1'b1, '{STAT_OK,       10'd0, 11'd8}},
            '{'{OP_GET,   32'h0000_0000, 8'h00, 11'd4},    1'b1, '{STAT_OK,       10'd0, 11'd4}},
            '{'{OP_SET,   32'h1234_0056, 8'hAB, 11'd16},   1'b0, none},
            '{'{OP_GET,   32'h1234_FF56, 8'hAB, 11'd100},  1'b0, none},
            '{'{OP_GET,   32'h1234_AB56, 8'h00, 11'd3},    1'b0, none},
            '{'{OP_SET,   32'hDEAD_BEEF, 8'hFF, 11'd2},    1'b0, none},
            '{'{OP_DEL,   32'h0000_0000, 8'h00, 11'd0},    1'b1, '{STAT_OK,       10'd0, 11'd0}},
            '{'{OP_GET,   32'h0000_0000, 8'h00, 11'd9},    1'b1, '{STAT_NOTFOUND, 10'd0, 11'd0}},
            '{'{OP_SET,   32'h0000_0055, 8'h00, 11'd5},    1'b0, none},
            '{'{OP_CLEAR, 32'h0000_0000, 8'h00, 11'd0},    1'b1, '{STAT_OK,       10'd0, 11'd0}}
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 0;  snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 83; snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;  snk_stall_pct = 83;
                end
                default: begin
                    src_idle_pct = 23; snk_stall_pct = 23;
                end
            endcase
            // hold the sender until the table has answered everything
            drain_results();
            send_req('{OP_CLEAR, 32'h0, 8'h0, 11'd0}, 1'b0, none);
            for (int k = 0; k < FILL_N; k++) begin
                send_req('{OP_SET, tag_pool[k], 8'h00, LEN_W'($urandom_range(1, 8))},
                         1'b0, none);
            end
            for (int k = 0; k < RAND_N; k++) begin
                pick_random(r);
                send_req(r, 1'b0, none);
                if ((ph == 0 || ph == 2) && k == 40) begin
                    hold_req = 1'b1;
                end
            end
        end

        snk_stall_pct = 0;
        drain_results();
        repeat (80) @(posedge aclk);

        $display("Sent %0d requests: %0d set, %0d get, %0d delete, %0d clear.",
                 op_cnt[0] + op_cnt[1] + op_cnt[2] + op_cnt[3],
                 op_cnt[OP_SET], op_cnt[OP_GET], op_cnt[OP_DEL], op_cnt[OP_CLEAR]);
        $display("Results: %0d ok, %0d bad length, %0d out of memory, %0d not found; %0d errors.",
                 st_cnt[STAT_OK], st_cnt[STAT_INVAL], st_cnt[STAT_OOM],
                 st_cnt[STAT_NOTFOUND], fail_count);
        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
